>>> rtl/core/mqf_pkg.sv
// ----------------------------------------------------------------------------
// mqf_pkg
// Shared types, codes and helpers of the MQTT control packet framer.
// ----------------------------------------------------------------------------
package mqf_pkg;

    localparam int MAX_SEGMENT_LEN = 127;
    localparam int LEN_W           = 7;
    localparam int NUM_SEG         = 5;
    localparam int SEG_W           = 3;
    localparam int ID_W            = 16;
    localparam int REM_W           = 10;
    localparam int Q_DEPTH         = 4;
    localparam int Q_AW            = $clog2(Q_DEPTH);
    localparam int PADDR_W         = 4;
    localparam int PDATA_W         = 32;

    localparam logic [2:0] CMD_CONNECT     = 3'd0;
    localparam logic [2:0] CMD_PUBLISH     = 3'd1;
    localparam logic [2:0] CMD_SUBSCRIBE   = 3'd2;
    localparam logic [2:0] CMD_UNSUBSCRIBE = 3'd3;
    localparam logic [2:0] CMD_PING        = 3'd4;
    localparam logic [2:0] CMD_DISCONNECT  = 3'd5;
    localparam logic [2:0] CMD_BODY        = 3'd6;

    localparam logic [1:0] REG_KEEP_ALIVE = 2'd0;
    localparam logic [1:0] REG_CONN_FLAGS = 2'd1;
    localparam logic [1:0] REG_SUB_QOS    = 2'd2;

    localparam logic [15:0] KEEP_ALIVE_RST = 16'hFFFF;
    localparam logic [7:0]  CONN_FLAGS_RST = 8'hCE;
    localparam logic [1:0]  SUB_QOS_RST    = 2'd1;
    localparam logic [1:0]  SUB_QOS_MAX    = 2'd2;
    localparam logic [ID_W-1:0] ID_FIRST   = 16'h0001;
    localparam logic [ID_W-1:0] ID_LAST    = 16'hFFFF;

    localparam logic [7:0] HDR_CONNECT     = 8'h10;
    localparam logic [7:0] HDR_PUB_Q0      = 8'h30;
    localparam logic [7:0] HDR_PUB_Q1      = 8'h32;
    localparam logic [7:0] HDR_SUBSCRIBE   = 8'h82;
    localparam logic [7:0] HDR_UNSUBSCRIBE = 8'hA2;
    localparam logic [7:0] HDR_PINGREQ     = 8'hC0;
    localparam logic [7:0] HDR_DISCONNECT  = 8'hE0;
    localparam logic [7:0] BYTE_ZERO       = 8'h00;
    localparam logic [7:0] PROTO_NAME_LEN  = 8'h04;
    localparam logic [7:0] PROTO_LEVEL     = 8'h04;
    localparam logic [7:0] CHAR_M          = 8'h4D;
    localparam logic [7:0] CHAR_Q          = 8'h51;
    localparam logic [7:0] CHAR_T          = 8'h54;

    localparam logic [REM_W-1:0] REM_CONNECT = 10'd20;
    localparam logic [REM_W-1:0] REM_PUBLISH = 10'd2;
    localparam logic [REM_W-1:0] REM_PUB_ID  = 10'd2;
    localparam logic [REM_W-1:0] REM_SUB     = 10'd5;
    localparam logic [REM_W-1:0] REM_UNSUB   = 10'd4;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [2:0] {
        HK_BODY    = 3'd0,
        HK_CONNECT = 3'd1,
        HK_PUB     = 3'd2,
        HK_SUBS    = 3'd3,
        HK_CTRL    = 3'd4
    } t_head;

    typedef struct packed {
        t_head                    head;
        logic [7:0]               first;
        logic [LEN_W-1:0]         rem;
        logic                     err;
        logic [ID_W-1:0]          id;
        t_len [NUM_SEG-1:0]       lens;
        logic [SEG_W-1:0]         pair_start;
        logic [SEG_W-1:0]         pair_cnt;
        logic                     emit_id;
        logic                     emit_qos;
        logic                     close;
    } t_job;

    typedef struct packed {
        logic [15:0] keep_alive;
        logic [7:0]  conn_flags;
        logic [1:0]  sub_qos;
    } t_cfg;

    function automatic t_len sat_len(input t_len l);
        return (l > LEN_W'(MAX_SEGMENT_LEN)) ? LEN_W'(MAX_SEGMENT_LEN) : l;
    endfunction

    function automatic logic [ID_W-1:0] next_id(input logic [ID_W-1:0] id);
        return (id == ID_LAST) ? ID_FIRST : id + ID_FIRST;
    endfunction

    function automatic logic [3:0] head_last(input t_head h);
        case (h)
            HK_BODY:    return 4'd0;
            HK_CONNECT: return 4'd13;
            HK_PUB:     return 4'd3;
            HK_SUBS:    return 4'd5;
            HK_CTRL:    return 4'd1;
            default:    return 4'd0;
        endcase
    endfunction

endpackage

>>> rtl/core/mqf_ifs.sv
// ----------------------------------------------------------------------------
// mqf_ifs
// Request and result channels of the MQTT control packet framer.
// ----------------------------------------------------------------------------
interface mqf_req_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                command;
    logic [7:0]                data_byte;
    logic [mqf_pkg::LEN_W-1:0] len_a;
    logic [mqf_pkg::LEN_W-1:0] len_b;
    logic [mqf_pkg::LEN_W-1:0] len_c;
    logic [mqf_pkg::LEN_W-1:0] len_d;
    logic [mqf_pkg::LEN_W-1:0] len_e;
    logic                      qos_flag;

    modport source (
        output valid, command, data_byte, len_a, len_b, len_c, len_d, len_e, qos_flag,
        input  ready
    );
    modport sink (
        input  valid, command, data_byte, len_a, len_b, len_c, len_d, len_e, qos_flag,
        output ready
    );
endinterface

interface mqf_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       length_error;

    modport source (
        output valid, out_byte, packet_end, length_error,
        input  ready
    );
    modport sink (
        input  valid, out_byte, packet_end, length_error,
        output ready
    );
endinterface

>>> rtl/core/mqf_front.sv
// ----------------------------------------------------------------------------
// mqf_front
// Accepts requests, tracks the open packet and its segments, and turns each
// request that yields bytes into one byte-burst descriptor for the back end.
// ----------------------------------------------------------------------------
module mqf_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mqf_req_if.sink           i_req,
    input  logic              i_full,
    output logic              o_push,
    output mqf_pkg::t_job     o_job
);

    typedef enum logic [5:0] {
        K_IDLE    = 6'b000001,
        K_CONNECT = 6'b000010,
        K_PUB0    = 6'b000100,
        K_PUB1    = 6'b001000,
        K_SUB     = 6'b010000,
        K_UNSUB   = 6'b100000
    } t_kind;

    t_kind                                   r_kind, n_kind, kind_a;
    logic [mqf_pkg::SEG_W-1:0]               r_seg, n_seg, seg_a, k_hit;
    mqf_pkg::t_len                           r_left, n_left, left_a;
    mqf_pkg::t_len [mqf_pkg::NUM_SEG-1:0]    r_pend, n_pend, lens_in;
    logic [mqf_pkg::ID_W-1:0]                r_packet_id, n_packet_id;
    logic [mqf_pkg::REM_W-1:0]               rem;
    logic                                    accept, found, emits, do_close;
    mqf_pkg::t_job                           job;

    assign i_req.ready = !i_full;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        lens_in[0] = mqf_pkg::sat_len(i_req.len_a);
        lens_in[1] = mqf_pkg::sat_len(i_req.len_b);
        lens_in[2] = mqf_pkg::sat_len(i_req.len_c);
        lens_in[3] = mqf_pkg::sat_len(i_req.len_d);
        lens_in[4] = mqf_pkg::sat_len(i_req.len_e);
    end

    always_comb begin
        n_pend      = r_pend;
        n_packet_id = r_packet_id;
        kind_a      = K_IDLE;
        seg_a       = '0;
        left_a      = '0;
        emits       = 1'b0;
        do_close    = 1'b0;
        rem         = '0;
        found       = 1'b0;
        k_hit       = '0;
        job         = '0;
        job.head    = mqf_pkg::HK_BODY;

        case (i_req.command)
            mqf_pkg::CMD_BODY: begin
                kind_a = r_kind;
                seg_a  = r_seg;
                left_a = r_left;
                if (r_kind != K_IDLE && r_left != '0) begin
                    emits     = 1'b1;
                    job.first = i_req.data_byte;
                    left_a    = r_left - 1'b1;
                end
            end
            mqf_pkg::CMD_CONNECT: begin
                n_pend    = lens_in;
                rem       = mqf_pkg::REM_CONNECT + mqf_pkg::REM_W'(lens_in[0])
                            + mqf_pkg::REM_W'(lens_in[1]) + mqf_pkg::REM_W'(lens_in[2])
                            + mqf_pkg::REM_W'(lens_in[3]) + mqf_pkg::REM_W'(lens_in[4]);
                emits     = 1'b1;
                job.head  = mqf_pkg::HK_CONNECT;
                job.first = mqf_pkg::HDR_CONNECT;
                kind_a    = K_CONNECT;
                left_a    = lens_in[0];
            end
            mqf_pkg::CMD_PUBLISH: begin
                n_pend[0] = lens_in[0];
                n_pend[1] = lens_in[1];
                rem       = mqf_pkg::REM_PUBLISH + mqf_pkg::REM_W'(lens_in[0])
                            + mqf_pkg::REM_W'(lens_in[1])
                            + (i_req.qos_flag ? mqf_pkg::REM_PUB_ID : '0);
                emits     = 1'b1;
                job.head  = mqf_pkg::HK_PUB;
                job.first = i_req.qos_flag ? mqf_pkg::HDR_PUB_Q1 : mqf_pkg::HDR_PUB_Q0;
                kind_a    = i_req.qos_flag ? K_PUB1 : K_PUB0;
                left_a    = lens_in[0];
            end
            mqf_pkg::CMD_SUBSCRIBE, mqf_pkg::CMD_UNSUBSCRIBE: begin
                n_pend[0]   = lens_in[0];
                emits       = 1'b1;
                job.head    = mqf_pkg::HK_SUBS;
                job.id      = r_packet_id;
                n_packet_id = mqf_pkg::next_id(r_packet_id);
                left_a      = lens_in[0];
                if (i_req.command == mqf_pkg::CMD_SUBSCRIBE) begin
                    rem       = mqf_pkg::REM_SUB + mqf_pkg::REM_W'(lens_in[0]);
                    job.first = mqf_pkg::HDR_SUBSCRIBE;
                    kind_a    = K_SUB;
                end else begin
                    rem       = mqf_pkg::REM_UNSUB + mqf_pkg::REM_W'(lens_in[0]);
                    job.first = mqf_pkg::HDR_UNSUBSCRIBE;
                    kind_a    = K_UNSUB;
                end
            end
            mqf_pkg::CMD_PING, mqf_pkg::CMD_DISCONNECT: begin
                emits     = 1'b1;
                do_close  = 1'b1;
                job.head  = mqf_pkg::HK_CTRL;
                job.first = (i_req.command == mqf_pkg::CMD_PING) ?
                            mqf_pkg::HDR_PINGREQ : mqf_pkg::HDR_DISCONNECT;
            end
            default: begin
                kind_a = r_kind;
                seg_a  = r_seg;
                left_a = r_left;
            end
        endcase

        job.rem  = rem[mqf_pkg::LEN_W-1:0];
        job.err  = |rem[mqf_pkg::REM_W-1:mqf_pkg::LEN_W];
        job.lens = n_pend;

        n_kind = kind_a;
        n_seg  = seg_a;
        n_left = left_a;

        // walk past empty segments
        if (kind_a != K_IDLE && left_a == '0) begin
            case (kind_a)
                K_CONNECT: begin
                    if (seg_a < mqf_pkg::SEG_W'(mqf_pkg::NUM_SEG - 1)) begin
                        for (int k = 1; k < mqf_pkg::NUM_SEG; k++) begin
                            if (!found && mqf_pkg::SEG_W'(k) > seg_a && n_pend[k] != '0) begin
                                found = 1'b1;
                                k_hit = mqf_pkg::SEG_W'(k);
                            end
                        end
                        job.pair_start = seg_a + 1'b1;
                        if (found) begin
                            job.pair_cnt = k_hit - seg_a;
                            n_seg        = k_hit;
                            n_left       = n_pend[k_hit];
                        end else begin
                            job.pair_cnt = mqf_pkg::SEG_W'(mqf_pkg::NUM_SEG - 1) - seg_a;
                            do_close     = 1'b1;
                        end
                    end else begin
                        do_close = 1'b1;
                    end
                end
                K_PUB0, K_PUB1: begin
                    if (seg_a == '0) begin
                        if (kind_a == K_PUB1) begin
                            job.emit_id = 1'b1;
                            job.id      = r_packet_id;
                            n_packet_id = mqf_pkg::next_id(r_packet_id);
                        end
                        if (n_pend[1] != '0) begin
                            n_seg  = mqf_pkg::SEG_W'(1);
                            n_left = n_pend[1];
                        end else begin
                            do_close = 1'b1;
                        end
                    end else begin
                        do_close = 1'b1;
                    end
                end
                K_SUB: begin
                    job.emit_qos = 1'b1;
                    do_close     = 1'b1;
                end
                default: begin
                    do_close = 1'b1;
                end
            endcase
        end

        if (do_close) begin
            n_kind = K_IDLE;
            n_seg  = '0;
            n_left = '0;
        end
        job.close = do_close;
    end

    assign o_push = accept && emits;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind      <= K_IDLE;
            r_seg       <= '0;
            r_left      <= '0;
            r_packet_id <= mqf_pkg::ID_FIRST;
        end else if (accept) begin
            r_kind      <= n_kind;
            r_seg       <= n_seg;
            r_left      <= n_left;
            r_packet_id <= n_packet_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend <= n_pend;
        end
    end

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_packet_id != '0)
        else $error("packet identifier reached zero");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kind == K_IDLE |-> r_left == '0 && r_seg == '0)
        else $error("idle framer holds segment state");

endmodule

>>> rtl/core/mqf_queue.sv
// ----------------------------------------------------------------------------
// mqf_queue
// Short descriptor queue between the front and the back end.
// ----------------------------------------------------------------------------
module mqf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mqf_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output mqf_pkg::t_job o_job
);

    mqf_pkg::t_job             r_mem [mqf_pkg::Q_DEPTH];
    logic [mqf_pkg::Q_AW-1:0]  r_wp, r_rp;
    logic [mqf_pkg::Q_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (mqf_pkg::Q_AW + 1)'(mqf_pkg::Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full || i_pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");

endmodule

>>> rtl/core/mqf_back.sv
// ----------------------------------------------------------------------------
// mqf_back
// Expands queued descriptors into packet bytes, one per cycle while the
// output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module mqf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mqf_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  mqf_pkg::t_job i_job,
    output logic          o_pop,
    mqf_res_if.source     o_res
);

    typedef enum logic [3:0] {
        PH_HEAD = 4'b0001,
        PH_PAIR = 4'b0010,
        PH_ID   = 4'b0100,
        PH_QOS  = 4'b1000
    } t_phase;

    t_phase                    r_phase, nxt_phase;
    logic [3:0]                r_idx;
    logic                      r_out_valid, r_out_end, r_out_err;
    logic [7:0]                r_out_byte;
    logic [7:0]                cur_byte, qos_byte;
    logic                      cur_err, last_in_phase, has_next, done, adv;
    logic [mqf_pkg::SEG_W-1:0] pair_k;
    mqf_pkg::t_job             j;

    assign j        = i_job;
    assign adv      = !r_out_valid || o_res.ready;
    assign pair_k   = j.pair_start + mqf_pkg::SEG_W'(r_idx[3:1]);
    assign qos_byte = (i_cfg.sub_qos > mqf_pkg::SUB_QOS_MAX) ?
                      8'(mqf_pkg::SUB_QOS_MAX) : 8'(i_cfg.sub_qos);

    always_comb begin
        cur_byte      = mqf_pkg::BYTE_ZERO;
        cur_err       = 1'b0;
        last_in_phase = 1'b1;
        case (r_phase)
            PH_HEAD: begin
                last_in_phase = (r_idx == mqf_pkg::head_last(j.head));
                if (r_idx == 4'd0) begin
                    cur_byte = j.first;
                end else if (r_idx == 4'd1 && j.head != mqf_pkg::HK_CTRL) begin
                    cur_byte = 8'(j.rem);
                    cur_err  = j.err;
                end else begin
                    case (j.head)
                        mqf_pkg::HK_CONNECT: begin
                            case (r_idx)
                                4'd3:    cur_byte = mqf_pkg::PROTO_NAME_LEN;
                                4'd4:    cur_byte = mqf_pkg::CHAR_M;
                                4'd5:    cur_byte = mqf_pkg::CHAR_Q;
                                4'd6:    cur_byte = mqf_pkg::CHAR_T;
                                4'd7:    cur_byte = mqf_pkg::CHAR_T;
                                4'd8:    cur_byte = mqf_pkg::PROTO_LEVEL;
                                4'd9:    cur_byte = i_cfg.conn_flags;
                                4'd10:   cur_byte = i_cfg.keep_alive[15:8];
                                4'd11:   cur_byte = i_cfg.keep_alive[7:0];
                                4'd13:   cur_byte = 8'(j.lens[0]);
                                default: cur_byte = mqf_pkg::BYTE_ZERO;
                            endcase
                        end
                        mqf_pkg::HK_PUB: begin
                            cur_byte = (r_idx == 4'd3) ? 8'(j.lens[0]) : mqf_pkg::BYTE_ZERO;
                        end
                        mqf_pkg::HK_SUBS: begin
                            case (r_idx)
                                4'd2:    cur_byte = j.id[15:8];
                                4'd3:    cur_byte = j.id[7:0];
                                4'd5:    cur_byte = 8'(j.lens[0]);
                                default: cur_byte = mqf_pkg::BYTE_ZERO;
                            endcase
                        end
                        default: cur_byte = mqf_pkg::BYTE_ZERO;
                    endcase
                end
            end
            PH_PAIR: begin
                last_in_phase = (r_idx == {j.pair_cnt, 1'b0} - 4'd1);
                if (r_idx[0] && pair_k < mqf_pkg::SEG_W'(mqf_pkg::NUM_SEG)) begin
                    cur_byte = 8'(j.lens[pair_k]);
                end
            end
            PH_ID: begin
                last_in_phase = r_idx[0];
                cur_byte      = r_idx[0] ? j.id[7:0] : j.id[15:8];
            end
            PH_QOS: begin
                cur_byte = qos_byte;
            end
            default: begin
                last_in_phase = 1'b1;
            end
        endcase
    end

    always_comb begin
        nxt_phase = PH_QOS;
        has_next  = 1'b0;
        case (r_phase)
            PH_HEAD: begin
                if (j.pair_cnt != '0) begin
                    nxt_phase = PH_PAIR;
                    has_next  = 1'b1;
                end else if (j.emit_id) begin
                    nxt_phase = PH_ID;
                    has_next  = 1'b1;
                end else if (j.emit_qos) begin
                    nxt_phase = PH_QOS;
                    has_next  = 1'b1;
                end
            end
            PH_PAIR: begin
                if (j.emit_id) begin
                    nxt_phase = PH_ID;
                    has_next  = 1'b1;
                end else if (j.emit_qos) begin
                    nxt_phase = PH_QOS;
                    has_next  = 1'b1;
                end
            end
            PH_ID: begin
                if (j.emit_qos) begin
                    nxt_phase = PH_QOS;
                    has_next  = 1'b1;
                end
            end
            default: begin
                has_next = 1'b0;
            end
        endcase
    end

    assign done  = last_in_phase && !has_next;
    assign o_pop = adv && i_valid && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEAD;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= i_valid;
            if (i_valid) begin
                if (done) begin
                    r_phase <= PH_HEAD;
                    r_idx   <= '0;
                end else if (last_in_phase) begin
                    r_phase <= nxt_phase;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_out_byte <= cur_byte;
            r_out_end  <= done && j.close;
            r_out_err  <= cur_err;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.out_byte     = r_out_byte;
    assign o_res.packet_end   = r_out_end;
    assign o_res.length_error = r_out_err;

    a_end_not_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out_end && r_out_err))
        else $error("length error flagged on closing byte");

    a_pair_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && r_phase == PH_PAIR |-> j.pair_cnt != '0)
        else $error("prefix phase entered with no prefixes");

endmodule

>>> rtl/core/mqtt_control_packet_framer.sv
// ----------------------------------------------------------------------------
// mqtt_control_packet_framer
// MQTT 3.1.1 control packet framer: start and body requests in, packet
// bytes out, with an APB register port for keep alive, flags and QoS.
// ----------------------------------------------------------------------------
// The request channel takes one request per cycle while the four-entry
// descriptor queue has room. A body request produces one byte and, at the end
// of a segment, the following length prefixes, packet identifier or QoS byte;
// a start request produces a burst of 2 to 22 bytes. The output stage sends
// one byte per cycle while the receiver is ready, so an unstalled stream of
// body bytes runs at one byte per cycle, and after a start burst the request
// side stalls once the queue has filled until the output catches up.
// Registers should be written only while no packet bytes are in flight.
module mqtt_control_packet_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mqf_req_if.sink                       i_req,
    mqf_res_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mqf_pkg::PADDR_W-1:0]   paddr,
    input  logic [mqf_pkg::PDATA_W-1:0]   pwdata,
    output logic [mqf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    mqf_pkg::t_cfg r_cfg;
    mqf_pkg::t_job push_job, head_job;
    logic          push, pop, q_full, q_valid, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.keep_alive <= mqf_pkg::KEEP_ALIVE_RST;
            r_cfg.conn_flags <= mqf_pkg::CONN_FLAGS_RST;
            r_cfg.sub_qos    <= mqf_pkg::SUB_QOS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                mqf_pkg::REG_KEEP_ALIVE: r_cfg.keep_alive <= pwdata[15:0];
                mqf_pkg::REG_CONN_FLAGS: r_cfg.conn_flags <= pwdata[7:0];
                mqf_pkg::REG_SUB_QOS:    r_cfg.sub_qos    <= pwdata[1:0];
                default:                 r_cfg            <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            mqf_pkg::REG_KEEP_ALIVE: prdata = mqf_pkg::PDATA_W'(r_cfg.keep_alive);
            mqf_pkg::REG_CONN_FLAGS: prdata = mqf_pkg::PDATA_W'(r_cfg.conn_flags);
            mqf_pkg::REG_SUB_QOS:    prdata = mqf_pkg::PDATA_W'(r_cfg.sub_qos);
            default:                 prdata = '0;
        endcase
    end

    mqf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (push),
        .o_job   (push_job)
    );

    mqf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    mqf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MQTT control packet framer. Start and body
// requests go in over the request channel, registers over APB; a local model
// of the framer predicts every packet byte with its end and length error
// marks, and each byte leaving the block is compared in order.
// ----------------------------------------------------------------------------
module tb_top;
    import mqf_pkg::*;

    localparam logic [2:0] CMD_NONE   = 3'd7;
    localparam int         IDLE_LIMIT = 4000;
    localparam int         SETTLE     = 24;

    typedef enum logic [2:0] {
        PK_CONNECT = 3'd0,
        PK_PUB0    = 3'd1,
        PK_SUB     = 3'd2,
        PK_UNSUB   = 3'd3,
        PK_PUB1    = 3'd4,
        PK_IDLE    = 3'd7
    } t_pkt_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } t_frame_byte;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    mqf_req_if req_if ();
    mqf_res_if res_if ();

    mqtt_control_packet_framer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // framer model state
    logic [15:0]     cfg_keep_alive = KEEP_ALIVE_RST;
    logic [7:0]      cfg_conn_flags = CONN_FLAGS_RST;
    logic [1:0]      cfg_sub_qos    = SUB_QOS_RST;
    t_pkt_kind       pkt_kind       = PK_IDLE;
    logic [2:0]      seg_idx        = '0;
    logic [6:0]      seg_left       = '0;
    logic [6:0]      seg_lens [5]   = '{default: '0};
    logic [15:0]     pkt_id         = ID_FIRST;

    t_frame_byte     frame_q [$];
    t_frame_byte     step_q [$];
    logic            step_closed;

    int              mismatches    = 0;
    int              req_sent      = 0;
    int              src_idle_pct  = 0;
    int              snk_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void put_byte(logic [7:0] b, logic e);
        step_q.push_back('{data: b, last: 1'b0, err: e});
    endfunction

    function automatic void put_id();
        put_byte(pkt_id[15:8], 1'b0);
        put_byte(pkt_id[7:0], 1'b0);
        pkt_id = (pkt_id == 16'hFFFF) ? 16'h0001 : pkt_id + 16'h0001;
    endfunction

    function automatic void close_pkt();
        pkt_kind    = PK_IDLE;
        seg_idx     = '0;
        seg_left    = '0;
        step_closed = 1'b1;
    endfunction

    function automatic void open_seg(logic [2:0] idx);
        seg_idx  = idx;
        seg_left = seg_lens[idx];
    endfunction

    function automatic void next_segment();
        while (pkt_kind != PK_IDLE && seg_left == 0) begin
            case (pkt_kind)
                PK_CONNECT: begin
                    if (seg_idx < 3'd4) begin
                        open_seg(seg_idx + 3'd1);
                        put_byte(BYTE_ZERO, 1'b0);
                        put_byte({1'b0, seg_left}, 1'b0);
                    end else begin
                        close_pkt();
                    end
                end
                PK_PUB0, PK_PUB1: begin
                    if (seg_idx == 3'd0) begin
                        if (pkt_kind == PK_PUB1) put_id();
                        open_seg(3'd1);
                    end else begin
                        close_pkt();
                    end
                end
                PK_SUB: begin
                    put_byte({6'd0, (cfg_sub_qos == 2'd3) ? SUB_QOS_MAX : cfg_sub_qos}, 1'b0);
                    close_pkt();
                end
                default: close_pkt();
            endcase
        end
    endfunction

    function automatic void put_rem(int rem);
        put_byte(8'(rem & 127), rem > 127);
    endfunction

    // works out the bytes that one accepted request puts on the output
    function automatic void frame_request(logic [2:0] cmd, logic [7:0] data,
                                          logic [6:0] la, logic [6:0] lb, logic [6:0] lc,
                                          logic [6:0] ld, logic [6:0] le, logic q);
        step_q.delete();
        step_closed = 1'b0;
        if (cmd == CMD_BODY) begin
            if (pkt_kind != PK_IDLE && seg_left > 0) begin
                put_byte(data, 1'b0);
                seg_left = seg_left - 7'd1;
                next_segment();
            end
        end else if (cmd != CMD_NONE) begin
            pkt_kind = PK_IDLE;
            seg_idx  = '0;
            seg_left = '0;
            case (cmd)
                CMD_CONNECT: begin
                    seg_lens = '{la, lb, lc, ld, le};
                    put_byte(HDR_CONNECT, 1'b0);
                    put_rem(20 + la + lb + lc + ld + le);
                    put_byte(BYTE_ZERO, 1'b0);
                    put_byte(PROTO_NAME_LEN, 1'b0);
                    put_byte(CHAR_M, 1'b0);
                    put_byte(CHAR_Q, 1'b0);
                    put_byte(CHAR_T, 1'b0);
                    put_byte(CHAR_T, 1'b0);
                    put_byte(PROTO_LEVEL, 1'b0);
                    put_byte(cfg_conn_flags, 1'b0);
                    put_byte(cfg_keep_alive[15:8], 1'b0);
                    put_byte(cfg_keep_alive[7:0], 1'b0);
                    put_byte(BYTE_ZERO, 1'b0);
                    put_byte({1'b0, la}, 1'b0);
                    pkt_kind = PK_CONNECT;
                    open_seg(3'd0);
                    next_segment();
                end
                CMD_PUBLISH: begin
                    seg_lens[0] = la;
                    seg_lens[1] = lb;
                    put_byte(q ? HDR_PUB_Q1 : HDR_PUB_Q0, 1'b0);
                    put_rem(2 + la + lb + (q ? 2 : 0));
                    put_byte(BYTE_ZERO, 1'b0);
                    put_byte({1'b0, la}, 1'b0);
                    pkt_kind = q ? PK_PUB1 : PK_PUB0;
                    open_seg(3'd0);
                    next_segment();
                end
                CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: begin
                    seg_lens[0] = la;
                    put_byte((cmd == CMD_SUBSCRIBE) ? HDR_SUBSCRIBE : HDR_UNSUBSCRIBE, 1'b0);
                    put_rem(((cmd == CMD_SUBSCRIBE) ? 5 : 4) + la);
                    put_id();
                    put_byte(BYTE_ZERO, 1'b0);
                    put_byte({1'b0, la}, 1'b0);
                    pkt_kind = (cmd == CMD_SUBSCRIBE) ? PK_SUB : PK_UNSUB;
                    open_seg(3'd0);
                    next_segment();
                end
                default: begin
                    put_byte((cmd == CMD_PING) ? HDR_PINGREQ : HDR_DISCONNECT, 1'b0);
                    put_byte(BYTE_ZERO, 1'b0);
                    close_pkt();
                end
            endcase
        end
        if (step_closed && step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[k]) frame_q.push_back(step_q[k]);
    endfunction

    // predict on request acceptance, compare on result acceptance
    always @(posedge i_clk) begin : scoreboard
        t_frame_byte want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                frame_request(req_if.command, req_if.data_byte, req_if.len_a, req_if.len_b,
                              req_if.len_c, req_if.len_d, req_if.len_e, req_if.qos_flag);
            end
            if (res_if.valid && res_if.ready) begin
                if (frame_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t unexpected byte %02h end %b err %b", $realtime,
                                 res_if.out_byte, res_if.packet_end, res_if.length_error);
                    mismatches++;
                end else begin
                    want = frame_q.pop_front();
                    if (res_if.out_byte !== want.data || res_if.packet_end !== want.last ||
                        res_if.length_error !== want.err) begin
                        if (mismatches < 10)
                            $display("%0t byte exp %02h/%b/%b got %02h/%b/%b", $realtime,
                                     want.data, want.last, want.err, res_if.out_byte,
                                     res_if.packet_end, res_if.length_error);
                        mismatches++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) res_if.ready <= ($urandom_range(99) >= snk_stall_pct);

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_req(logic [2:0] cmd, logic [7:0] data, logic [6:0] la, logic [6:0] lb,
                            logic [6:0] lc, logic [6:0] ld, logic [6:0] le, logic q);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.command   <= cmd;
        req_if.data_byte <= data;
        req_if.len_a     <= la;
        req_if.len_b     <= lb;
        req_if.len_c     <= lc;
        req_if.len_d     <= ld;
        req_if.len_e     <= le;
        req_if.qos_flag  <= q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        req_sent++;
    endtask

    function automatic logic [6:0] any_len();
        return 7'($urandom_range(127));
    endfunction

    task automatic send_body(logic [2:0] cmd);
        send_req(cmd, 8'($urandom_range(255)), any_len(), any_len(), any_len(), any_len(),
                 any_len(), 1'($urandom_range(1)));
    endtask

    function automatic int body_count(logic [2:0] cmd, logic [6:0] la, logic [6:0] lb,
                                      logic [6:0] lc, logic [6:0] ld, logic [6:0] le);
        case (cmd)
            CMD_CONNECT:                   return la + lb + lc + ld + le;
            CMD_PUBLISH:                   return la + lb;
            CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: return la;
            default:                       return 0;
        endcase
    endfunction

    task automatic send_packet(logic [2:0] cmd, logic [6:0] la, logic [6:0] lb, logic [6:0] lc,
                               logic [6:0] ld, logic [6:0] le, logic q);
        send_req(cmd, 8'($urandom_range(255)), la, lb, lc, ld, le, q);
        repeat (body_count(cmd, la, lb, lc, ld, le)) send_body(CMD_BODY);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (frame_q.size() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_KEEP_ALIVE: cfg_keep_alive = value[15:0];
            REG_CONN_FLAGS: cfg_conn_flags = value[7:0];
            REG_SUB_QOS:    cfg_sub_qos    = value[1:0];
            default: ;
        endcase
    endtask

    // reset register values, every packet kind, empty segments in between and at the end
    task automatic test_every_command();
        send_packet(CMD_CONNECT, 7'd1, 7'd0, 7'd1, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_PUBLISH, 7'd0, 7'd1, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_PUBLISH, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
        send_packet(CMD_SUBSCRIBE, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_UNSUBSCRIBE, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_PING, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_DISCONNECT, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
    endtask

    // body bytes with no packet open and the unused command code, also in an open packet
    task automatic test_stray_requests();
        send_body(CMD_BODY);
        send_body(CMD_NONE);
        send_req(CMD_PUBLISH, 8'hFF, 7'd1, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_body(CMD_NONE);
        send_req(CMD_BODY, 8'h00, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_req(CMD_BODY, 8'hFF, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 1'b1);
    endtask

    // oversized remaining lengths, each packet abandoned by the next start
    task automatic test_length_error();
        send_req(CMD_CONNECT, 8'h00, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 7'h7F, 1'b0);
        send_body(CMD_BODY);
        send_body(CMD_BODY);
        send_req(CMD_SUBSCRIBE, 8'hA5, 7'h7F, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
        send_body(CMD_BODY);
        send_packet(CMD_PING, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b1);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_KEEP_ALIVE, 32'h0000_0000);
        write_reg(REG_CONN_FLAGS, 32'h0000_0000);
        write_reg(REG_SUB_QOS, 32'h0000_0000);
        send_packet(CMD_CONNECT, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_SUBSCRIBE, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        write_reg(REG_KEEP_ALIVE, 32'h0000_FFFF);
        write_reg(REG_CONN_FLAGS, 32'h0000_00FF);
        write_reg(REG_SUB_QOS, 32'h0000_0003);
        send_packet(CMD_CONNECT, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        send_packet(CMD_SUBSCRIBE, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
        write_reg(REG_SUB_QOS, 32'h0000_0002);
        send_packet(CMD_SUBSCRIBE, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0);
    endtask

    function automatic logic [6:0] short_len();
        int r;
        r = $urandom_range(99);
        if (r < 85) return 7'($urandom_range(6));
        if (r < 95) return 7'($urandom_range(40, 7));
        return 7'($urandom_range(127, 41));
    endfunction

    task automatic random_packet();
        logic [2:0] cmd;
        logic [6:0] l [5];
        logic       q;
        int         n;
        cmd = 3'($urandom_range(5));
        foreach (l[k]) l[k] = any_len();
        case (cmd)
            CMD_CONNECT: foreach (l[k]) l[k] = short_len();
            CMD_PUBLISH: begin
                l[0] = short_len();
                l[1] = short_len();
            end
            CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: l[0] = short_len();
            default: ;
        endcase
        q = 1'($urandom_range(1));
        send_req(cmd, 8'($urandom_range(255)), l[0], l[1], l[2], l[3], l[4], q);
        n = body_count(cmd, l[0], l[1], l[2], l[3], l[4]);
        // broken sequence: cut short, the next start abandons it
        if ($urandom_range(9) == 0) n = $urandom_range(n);
        repeat (n) begin
            if ($urandom_range(24) == 0) send_body(CMD_NONE);
            send_body(CMD_BODY);
        end
        if ($urandom_range(9) == 0) send_body(CMD_BODY);
    endtask

    task automatic test_random_traffic();
        int src_pct [4] = '{0, 71, 0, 12};
        int snk_pct [4] = '{0, 0, 71, 12};
        int goal;
        for (int p = 0; p < 4; p++) begin
            write_reg(REG_KEEP_ALIVE, 32'($urandom_range(16'hFFFF)));
            write_reg(REG_CONN_FLAGS, 32'($urandom_range(8'hFF)));
            write_reg(REG_SUB_QOS, 32'(p));
            src_idle_pct  = src_pct[p];
            snk_stall_pct = snk_pct[p];
            goal = req_sent + 76;
            while (req_sent < goal) begin
                random_packet();
                if ($urandom_range(14) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.command   <= CMD_NONE;
        req_if.data_byte <= '0;
        req_if.len_a     <= '0;
        req_if.len_b     <= '0;
        req_if.len_c     <= '0;
        req_if.len_d     <= '0;
        req_if.len_e     <= '0;
        req_if.qos_flag  <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_every_command();
        test_stray_requests();
        test_length_error();
        test_register_extremes();
        test_random_traffic();

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (frame_q.size() != 0) begin
            $display("%0d predicted bytes never arrived", frame_q.size());
            mismatches += frame_q.size();
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
